// File: design/slptlv_pkg.sv
// Shared constants for the SLIP TLV packet receiver.
`default_nettype none
package slptlv_pkg;

  localparam int unsigned MAX_VALUE_LEN_DEFAULT = 64;

  localparam logic [31:0] CRC_POLY_RESET = 32'hEDB88320;

  // SLIP special characters.
  localparam logic [7:0] CHR_END     = 8'hC0;
  localparam logic [7:0] CHR_ESC     = 8'hDB;
  localparam logic [7:0] CHR_ESC_END = 8'hDC;
  localparam logic [7:0] CHR_ESC_ESC = 8'hDD;

  // Frame parser positions.
  localparam logic [3:0] PS_TAG   = 4'd0;
  localparam logic [3:0] PS_ID0   = 4'd1;
  localparam logic [3:0] PS_ID1   = 4'd2;
  localparam logic [3:0] PS_ID2   = 4'd3;
  localparam logic [3:0] PS_ID3   = 4'd4;
  localparam logic [3:0] PS_LEN0  = 4'd5;
  localparam logic [3:0] PS_LEN1  = 4'd6;
  localparam logic [3:0] PS_VALUE = 4'd7;
  localparam logic [3:0] PS_CRC0  = 4'd8;
  localparam logic [3:0] PS_CRC1  = 4'd9;
  localparam logic [3:0] PS_CRC2  = 4'd10;
  localparam logic [3:0] PS_CRC3  = 4'd11;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CRC  = 3'b010,
    S_EMIT = 3'b100
  } state_t;

endpackage
`default_nettype wire

// File: design/slip_tlv_packet_receiver_top.sv
// SLIP deframer with tag/id/length/value parsing and CRC-32 check.
`default_nettype none
// One SLIP-encoded byte is taken per request. END, ESC and the four CRC bytes
// of a frame are handled in their accept cycle. Each byte covered by the CRC
// (tag, id, length, value) moves the block into a CRC state in which a single
// shift-and-xor unit folds one bit per cycle into the running CRC under the
// configured reflected polynomial. After the last CRC byte matches, the frame
// is emitted from the value store at one result per cycle while out_ready is
// high (one result for an empty frame); no byte is taken until the result
// marked last is delivered. The polynomial register must be written only
// while the block is idle (not enforced); its write channel is always ready.
module slip_tlv_packet_receiver_top
  import slptlv_pkg::*;
#(
  parameter int unsigned MAX_VALUE_LEN = MAX_VALUE_LEN_DEFAULT
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       frame_tag,
  output logic [31:0]      frame_id,
  output logic [6:0]       value_length,
  output logic             has_value,
  output logic [7:0]       value_byte,
  output logic [5:0]       value_index,
  output logic             last
);

  localparam int unsigned AW = (MAX_VALUE_LEN > 1) ? $clog2(MAX_VALUE_LEN) : 1;
  localparam logic [15:0] MAX_LEN16 = 16'(MAX_VALUE_LEN);

  state_t      state, state_next;
  logic        esc, esc_next;
  logic [3:0]  parse_state, parse_state_next;
  logic [31:0] crc_poly;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [7:0]  held_tag, held_tag_next;
  logic [31:0] held_id, held_id_next;
  logic [15:0] held_length, held_length_next;
  logic [6:0]  bytes_taken, bytes_taken_next;
  logic [2:0]  bit_cnt, bit_cnt_next;
  logic [6:0]  emit_idx, emit_idx_next;

  logic [7:0]  value_store [MAX_VALUE_LEN];
  logic        mem_we;
  logic [AW-1:0] mem_waddr;
  logic [AW-1:0] mem_raddr;
  logic [7:0]  rd_data;

  logic [7:0]  ub;
  logic        take;
  logic [15:0] len_full;
  logic [31:0] exp_full;
  logic [31:0] crc_step;
  logic        emit_last;
  logic        out_acc;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT);
  assign out_acc   = out_valid && out_ready;

  assign len_full  = {ub, held_length[7:0]};
  assign exp_full  = {ub, expected_crc[23:0]};
  assign crc_step  = running_crc[0] ? ((running_crc >> 1) ^ crc_poly) : (running_crc >> 1);
  assign emit_last = (held_length == 16'd0) || ((emit_idx + 7'd1) == held_length[6:0]);

  always_comb begin
    state_next        = state;
    esc_next          = esc;
    parse_state_next  = parse_state;
    running_crc_next  = running_crc;
    expected_crc_next = expected_crc;
    held_tag_next     = held_tag;
    held_id_next      = held_id;
    held_length_next  = held_length;
    bytes_taken_next  = bytes_taken;
    bit_cnt_next      = bit_cnt;
    emit_idx_next     = emit_idx;
    mem_we            = 1'b0;
    ub                = rx_byte;
    take              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          priority if (rx_byte == CHR_END) begin
            esc_next         = 1'b0;
            parse_state_next = PS_TAG;
          end else if (!esc) begin
            if (rx_byte == CHR_ESC) begin
              esc_next = 1'b1;
            end else begin
              take = 1'b1;
            end
          end else begin
            esc_next = 1'b0;
            priority if (rx_byte == CHR_ESC_END) begin
              ub   = CHR_END;
              take = 1'b1;
            end else if (rx_byte == CHR_ESC_ESC) begin
              ub   = CHR_ESC;
              take = 1'b1;
            end else begin
              parse_state_next = PS_TAG;
            end
          end

          if (take) begin
            // Bytes up to the end of the value field go through the CRC unit.
            if (parse_state <= PS_VALUE) begin
              running_crc_next = ((parse_state == PS_TAG) ? 32'd0 : running_crc)
                                 ^ {24'd0, ub};
              bit_cnt_next     = 3'd0;
              state_next       = S_CRC;
            end
            unique case (parse_state)
              PS_TAG: begin
                held_tag_next    = ub;
                parse_state_next = PS_ID0;
              end
              PS_ID0: begin
                held_id_next     = {24'd0, ub};
                parse_state_next = PS_ID1;
              end
              PS_ID1: begin
                held_id_next[15:8] = ub;
                parse_state_next   = PS_ID2;
              end
              PS_ID2: begin
                held_id_next[23:16] = ub;
                parse_state_next    = PS_ID3;
              end
              PS_ID3: begin
                held_id_next[31:24] = ub;
                parse_state_next    = PS_LEN0;
              end
              PS_LEN0: begin
                held_length_next = {8'd0, ub};
                parse_state_next = PS_LEN1;
              end
              PS_LEN1: begin
                held_length_next = len_full;
                priority if (len_full > MAX_LEN16) begin
                  parse_state_next = PS_TAG;
                end else if (len_full == 16'd0) begin
                  parse_state_next = PS_CRC0;
                end else begin
                  bytes_taken_next = 7'd0;
                  parse_state_next = PS_VALUE;
                end
              end
              PS_VALUE: begin
                mem_we           = 1'b1;
                bytes_taken_next = bytes_taken + 7'd1;
                if ({9'd0, bytes_taken + 7'd1} >= held_length) begin
                  parse_state_next = PS_CRC0;
                end
              end
              PS_CRC0: begin
                expected_crc_next = {24'd0, ub};
                parse_state_next  = PS_CRC1;
              end
              PS_CRC1: begin
                expected_crc_next[15:8] = ub;
                parse_state_next        = PS_CRC2;
              end
              PS_CRC2: begin
                expected_crc_next[23:16] = ub;
                parse_state_next         = PS_CRC3;
              end
              PS_CRC3: begin
                expected_crc_next = exp_full;
                parse_state_next  = PS_TAG;
                if (exp_full == running_crc) begin
                  emit_idx_next = 7'd0;
                  state_next    = S_EMIT;
                end
              end
              default: begin
                parse_state_next = PS_TAG;
              end
            endcase
          end
        end
      end
      S_CRC: begin
        running_crc_next = crc_step;
        bit_cnt_next     = bit_cnt + 3'd1;
        if (bit_cnt == 3'd7) begin
          state_next = S_IDLE;
        end
      end
      S_EMIT: begin
        if (out_ready) begin
          if (emit_last) begin
            state_next = S_IDLE;
          end else begin
            emit_idx_next = emit_idx + 7'd1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      esc          <= 1'b0;
      parse_state  <= PS_TAG;
      crc_poly     <= CRC_POLY_RESET;
      running_crc  <= 32'd0;
      expected_crc <= 32'd0;
      held_tag     <= 8'd0;
      held_id      <= 32'd0;
      held_length  <= 16'd0;
      bytes_taken  <= 7'd0;
      bit_cnt      <= 3'd0;
      emit_idx     <= 7'd0;
    end else begin
      state        <= state_next;
      esc          <= esc_next;
      parse_state  <= parse_state_next;
      running_crc  <= running_crc_next;
      expected_crc <= expected_crc_next;
      held_tag     <= held_tag_next;
      held_id      <= held_id_next;
      held_length  <= held_length_next;
      bytes_taken  <= bytes_taken_next;
      bit_cnt      <= bit_cnt_next;
      emit_idx     <= emit_idx_next;
      if (cfg_valid) begin
        crc_poly <= cfg_data;
      end
    end
  end

  // When a result is taken, the read address moves on to the next entry, so the
  // registered read data is ready for the next result.
  assign mem_waddr = bytes_taken[AW-1:0];
  always_comb begin
    if (state != S_EMIT) begin
      mem_raddr = '0;
    end else if (out_acc && !emit_last) begin
      mem_raddr = AW'(emit_idx + 7'd1);
    end else begin
      mem_raddr = emit_idx[AW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      value_store[mem_waddr] <= ub;
    end
    rd_data <= value_store[mem_raddr];
  end

  assign has_value    = (held_length != 16'd0);
  assign frame_tag    = held_tag;
  assign frame_id     = held_id;
  assign value_length = held_length[6:0];
  assign value_byte   = has_value ? rd_data : 8'd0;
  assign value_index  = has_value ? emit_idx[5:0] : 6'd0;
  assign last         = emit_last;

endmodule
`default_nettype wire

// File: dv/testbench.sv
// Self-checking testbench for the SLIP TLV packet receiver with CRC-32 check.
module testbench;
  import slptlv_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_LEN = MAX_VALUE_LEN_DEFAULT;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_CUT} frame_kind_t;

  typedef struct {
    logic [7:0]  tag;
    logic [31:0] id;
    logic [6:0]  vlen;
    logic        hv;
    logic [7:0]  vbyte;
    logic [5:0]  vidx;
    logic        last;
  } frame_result_t;

  typedef struct {
    logic [7:0] b;
    bit         wait_drain;
  } link_item_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = 32'h0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  frame_tag;
  logic [31:0] frame_id;
  logic [6:0]  value_length;
  logic        has_value;
  logic [7:0]  value_byte;
  logic [5:0]  value_index;
  logic        last;

  slip_tlv_packet_receiver_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .frame_tag    (frame_tag),
    .frame_id     (frame_id),
    .value_length (value_length),
    .has_value    (has_value),
    .value_byte   (value_byte),
    .value_index  (value_index),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  link_item_t    link_bytes[$];
  frame_result_t due_results[$];
  int            err_count = 0;
  int            gen_bytes = 0;
  int            gen_results = 0;
  bit            hold_next = 1'b0;

  // Deframer shadow state.
  logic [31:0] crc_poly = CRC_POLY_RESET;
  logic        after_esc = 1'b0;
  logic [3:0]  pstate = PS_TAG;
  logic [31:0] run_crc = 32'h0;
  logic [31:0] rx_crc = 32'h0;
  logic [7:0]  held_tag = 8'h0;
  logic [31:0] held_id = 32'h0;
  logic [15:0] held_len = 16'h0;
  logic [6:0]  taken = 7'h0;
  logic [7:0]  value_mem [64];

  function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b,
                                           input logic [31:0] poly);
    logic [31:0] c;
    c = crc ^ {24'h0, b};
    for (int i = 0; i < 8; i++) c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
    return c;
  endfunction

  function automatic void emit_frame();
    frame_result_t r;
    r.tag = held_tag;
    r.id  = held_id;
    if (held_len == 16'h0) begin
      r.vlen = 7'h0; r.hv = 1'b0; r.vbyte = 8'h0; r.vidx = 6'h0; r.last = 1'b1;
      due_results.push_back(r);
    end else begin
      for (int k = 0; k < held_len; k++) begin
        r.vlen  = held_len[6:0];
        r.hv    = 1'b1;
        r.vbyte = value_mem[k];
        r.vidx  = k[5:0];
        r.last  = (k + 1 == held_len);
        due_results.push_back(r);
      end
    end
  endfunction

  // Unstuffs and parses one accepted link byte, queuing any results it releases.
  function automatic void deframe_byte(input logic [7:0] raw);
    logic [7:0] b;
    b = raw;
    if (b == CHR_END) begin
      after_esc = 1'b0;
      pstate = PS_TAG;
      return;
    end
    if (!after_esc) begin
      if (b == CHR_ESC) begin
        after_esc = 1'b1;
        return;
      end
    end else begin
      after_esc = 1'b0;
      if (b == CHR_ESC_END) b = CHR_END;
      else if (b == CHR_ESC_ESC) b = CHR_ESC;
      else begin
        pstate = PS_TAG;
        return;
      end
    end
    case (pstate)
      PS_TAG: begin
        run_crc = crc_fold(32'h0, b, crc_poly);
        held_tag = b;
        pstate = PS_ID0;
      end
      PS_ID0, PS_ID1, PS_ID2, PS_ID3: begin
        run_crc = crc_fold(run_crc, b, crc_poly);
        if (pstate == PS_ID0) held_id = {24'h0, b};
        else held_id[8*(pstate - PS_ID0) +: 8] = b;
        pstate = pstate + 4'd1;
      end
      PS_LEN0: begin
        run_crc = crc_fold(run_crc, b, crc_poly);
        held_len = {8'h0, b};
        pstate = PS_LEN1;
      end
      PS_LEN1: begin
        run_crc = crc_fold(run_crc, b, crc_poly);
        held_len[15:8] = b;
        if (held_len > MAX_LEN) pstate = PS_TAG;
        else if (held_len == 16'h0) pstate = PS_CRC0;
        else begin
          taken = 7'h0;
          pstate = PS_VALUE;
        end
      end
      PS_VALUE: begin
        run_crc = crc_fold(run_crc, b, crc_poly);
        value_mem[taken[5:0]] = b;
        taken = taken + 7'd1;
        if (taken >= held_len) pstate = PS_CRC0;
      end
      PS_CRC0, PS_CRC1, PS_CRC2, PS_CRC3: begin
        if (pstate == PS_CRC0) rx_crc = {24'h0, b};
        else rx_crc[8*(pstate - PS_CRC0) +: 8] = b;
        if (pstate == PS_CRC3) begin
          pstate = PS_TAG;
          if (rx_crc == run_crc) emit_frame();
        end else begin
          pstate = pstate + 4'd1;
        end
      end
      default: pstate = PS_TAG;
    endcase
  endfunction

  task automatic report(input string msg);
    err_count++;
    if (err_count <= 40) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) report($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Stimulus construction.
  function automatic void push_link(input logic [7:0] b);
    link_item_t it;
    it.b = b;
    it.wait_drain = hold_next;
    hold_next = 1'b0;
    link_bytes.push_back(it);
    gen_bytes++;
  endfunction

  function automatic void push_escaped(input logic [7:0] b);
    if (b == CHR_END) begin
      push_link(CHR_ESC);
      push_link(CHR_ESC_END);
    end else if (b == CHR_ESC) begin
      push_link(CHR_ESC);
      push_link(CHR_ESC_ESC);
    end else begin
      push_link(b);
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 7))
      0: return CHR_END;
      1: return CHR_ESC;
      2: return CHR_ESC_END;
      3: return CHR_ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] data_byte();
    case ($urandom_range(0, 9))
      0: return CHR_END;
      1: return CHR_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 80) return 16'($urandom_range(0, 8));
    else if (p < 95) return 16'($urandom_range(9, 24));
    else return 16'($urandom_range(25, MAX_LEN));
  endfunction

  function automatic logic [15:0] overlong_len();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(MAX_LEN + 1, 255));
    else return {8'($urandom_range(1, 255)), 8'($urandom)};
  endfunction

  task automatic add_frame(input logic [7:0] tag, input logic [31:0] id, input logic [15:0] len,
                           input frame_kind_t kind, input bit lead_end);
    logic [7:0]  raw[$];
    logic [31:0] crc;
    int          cut;
    if (lead_end) push_link(CHR_END);
    raw.push_back(tag);
    for (int i = 0; i < 4; i++) raw.push_back(id[8*i +: 8]);
    raw.push_back(len[7:0]);
    raw.push_back(len[15:8]);
    if (len <= MAX_LEN) begin
      for (int i = 0; i < len; i++) raw.push_back(data_byte());
      crc = 32'h0;
      foreach (raw[i]) crc = crc_fold(crc, raw[i], crc_poly);
      if (kind == FR_BAD_CRC) crc ^= 32'h1 << $urandom_range(0, 31);
      for (int i = 0; i < 4; i++) raw.push_back(crc[8*i +: 8]);
      if (kind == FR_GOOD) gen_results += (len == 16'h0) ? 1 : int'(len);
    end
    if (kind == FR_CUT) begin
      cut = $urandom_range(1, raw.size() - 1);
      while (raw.size() > cut) void'(raw.pop_back());
    end
    foreach (raw[i]) push_escaped(raw[i]);
  endtask

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) push_link(noise_byte());
  endtask

  task automatic random_phase(input int n_bytes, input int n_results, input bit with_max);
    int b0;
    int r0;
    int pick;
    bit messy;
    b0 = gen_bytes;
    r0 = gen_results;
    messy = 1'b1;
    hold_next = 1'b1;
    if (with_max) begin
      add_frame(8'($urandom), $urandom, 16'(MAX_LEN), FR_GOOD, 1'b1);
      messy = 1'b0;
    end
    while (gen_bytes - b0 < n_bytes || gen_results - r0 < n_results) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 7) == 0) hold_next = 1'b1;
      if (pick < 60) begin
        add_frame(8'($urandom), $urandom, pick_len(), FR_GOOD, messy || $urandom_range(0, 1));
        messy = 1'b0;
      end else if (pick < 70) begin
        add_frame(8'($urandom), $urandom, pick_len(), FR_BAD_CRC, messy || $urandom_range(0, 1));
        messy = 1'b0;
      end else if (pick < 78) begin
        add_frame(8'($urandom), $urandom, overlong_len(), FR_GOOD, 1'b1);
        add_noise($urandom_range(0, 4));
        push_link(CHR_END);
        messy = 1'b0;
      end else if (pick < 86) begin
        add_frame(8'($urandom), $urandom, pick_len(), FR_CUT, 1'b1);
        // A broken escape in the middle of the frame.
        if ($urandom_range(0, 1) == 0) begin
          push_link(CHR_ESC);
          push_link(8'($urandom_range(0, 8'hDB)));
        end
        messy = 1'b1;
      end else begin
        add_noise($urandom_range(1, 8));
        messy = 1'b1;
      end
    end
    push_link(CHR_END);
  endtask

  task automatic write_poly(input logic [31:0] poly);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= poly;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    crc_poly = poly;
  endtask

  task automatic wait_idle();
    while (link_bytes.size() != 0 || in_valid || due_results.size() != 0) @(posedge clk);
    // Trailing bytes may still be folding into the CRC.
    repeat (24) @(posedge clk);
  endtask

  // Sender: bursts of random length separated by random gaps.
  int         burst_left = 0;
  int         gap_left = 0;
  link_item_t next_item;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      burst_left = $urandom_range(1, 40);
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) deframe_byte(rx_byte);
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (link_bytes.size() != 0 &&
                     !(link_bytes[0].wait_drain && due_results.size() != 0)) begin
          next_item = link_bytes.pop_front();
          in_valid <= 1'b1;
          rx_byte  <= next_item.b;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: ready follows a rotating pattern that is redrawn now and then.
  logic [15:0] ready_pat = 16'hFFFF;
  int          pat_age = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      pat_age = 0;
    end else begin
      if (pat_age == 0) begin
        pat_age = $urandom_range(20, 200);
        case ($urandom_range(0, 3))
          0: ready_pat = 16'hFFFF;
          1: ready_pat = 16'($urandom);
          2: ready_pat = 16'($urandom) | 16'($urandom);
          default: ready_pat = 16'($urandom) & 16'($urandom);
        endcase
        ready_pat[0] = 1'b1;
      end
      pat_age--;
      ready_pat = {ready_pat[14:0], ready_pat[15]};
      out_ready <= ready_pat[0];
    end
  end

  // Result checker.
  frame_result_t want;

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (due_results.size() == 0) begin
        report($sformatf("unexpected result tag %0h id %0h index %0h",
                         frame_tag, frame_id, value_index));
      end else begin
        want = due_results.pop_front();
        check_field("frame_tag", frame_tag, want.tag);
        check_field("frame_id", frame_id, want.id);
        check_field("value_length", value_length, want.vlen);
        check_field("has_value", has_value, want.hv);
        check_field("value_byte", value_byte, want.vbyte);
        check_field("value_index", value_index, want.vidx);
        check_field("last", last, want.last);
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: escaped empty frame, broken escape, escape then END, over-long length.
    add_frame(CHR_END, 32'hFFDB0000, 16'h0000, FR_GOOD, 1'b1);
    push_link(CHR_ESC);
    push_link(8'h41);
    push_link(CHR_ESC);
    push_link(CHR_END);
    add_frame(8'hFF, 32'h00C0FF00, 16'(MAX_LEN + 1), FR_GOOD, 1'b0);
    push_link(CHR_END);
    wait_idle();

    random_phase(30, 8, 1'b1);
    wait_idle();
    write_poly(32'h0000_0000);
    random_phase(30, 8, 1'b0);
    wait_idle();
    write_poly(32'hFFFF_FFFF);
    random_phase(30, 8, 1'b0);
    wait_idle();
    write_poly($urandom);
    random_phase(30, 8, 1'b0);
    wait_idle();
    write_poly(CRC_POLY_RESET);
    random_phase(30, 8, 1'b0);
    wait_idle();

    if (due_results.size() != 0) report("results still expected at the end");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #1_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
